FILE: rtl/ipv4fhg_pkg.sv
// Shared types and constants for the IPv4 fragment header generator.
// No dependencies; used by the checksum unit and the top level.
package ipv4fhg_pkg;

   localparam int unsigned HDR_BYTES  = 20;
   localparam int unsigned NUM_WORDS  = 10;
   localparam int unsigned WORD_CNT_W = $clog2(NUM_WORDS);

   localparam logic [15:0] VER_IHL_TOS = 16'h4500;
   localparam logic [7:0]  TTL_VALUE   = 8'd64;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FRAG,
      ST_SUM,
      ST_SEND
   } state_type;

   // Control from the sequencer to the shared checksum adder
   typedef struct packed {
      logic clear;
      logic add;
   } csum_ctl_type;

endpackage

FILE: rtl/ipv4fhg_if.sv
// Handshake channels of the IPv4 fragment header generator: request,
// response and register write. Valid/ready with payload; no dependencies.
interface ipv4fhg_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] payload_len;
   logic [31:0] dst_ip;
   logic [7:0]  protocol;

   modport source (output valid, payload_len, dst_ip, protocol, input ready);
   modport sink   (input valid, payload_len, dst_ip, protocol, output ready);
endinterface

interface ipv4fhg_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] total_len;
   logic [15:0] ident;
   logic        more_frags;
   logic [12:0] frag_offset;
   logic [7:0]  proto_out;
   logic [31:0] dst_out;
   logic [15:0] hdr_checksum;
   logic        last;

   modport source (output valid, total_len, ident, more_frags, frag_offset, proto_out,
                   dst_out, hdr_checksum, last, input ready);
   modport sink   (input valid, total_len, ident, more_frags, frag_offset, proto_out,
                   dst_out, hdr_checksum, last, output ready);
endinterface

interface ipv4fhg_csr_if;
   logic        valid;
   logic        ready;
   logic [31:0] local_ip;

   modport source (output valid, local_ip, input ready);
   modport sink   (input valid, local_ip, output ready);
endinterface

FILE: rtl/ipv4fhg_csum.sv
// Shared one's-complement adder for the IPv4 header checksum: one 16-bit
// word per cycle while ctl.add is set, with end-around carry. Depends on ipv4fhg_pkg.
module ipv4fhg_csum (
   input  logic                      clock,
   input  ipv4fhg_pkg::csum_ctl_type ctl,
   input  logic [15:0]               word,
   output logic [15:0]               checksum
);

   logic [15:0] acc_ff;
   logic [15:0] acc_in;
   logic [16:0] raw_sum;

   assign raw_sum = {1'b0, acc_ff} + {1'b0, word};

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.add) begin
         // fold the carry back in; cannot carry out again
         acc_in = raw_sum[15:0] + {15'd0, raw_sum[16]};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign checksum = ~acc_ff;

endmodule

FILE: rtl/ipv4fhg_top.sv
// IPv4 fragment header generator top level: sequencer, fragment bookkeeping
// and response register. Depends on ipv4fhg_pkg, ipv4fhg_if and ipv4fhg_csum.
//
//   channel  direction  handshake     carries
//   req_if   in         valid/ready   payload_len, dst_ip, protocol
//   rsp_if   out        valid/ready   one IPv4 header per fragment
//   csr_if   in         valid/ready   local_ip (source address), always ready
//
// A request is taken only while idle. Each fragment passes through ST_FRAG,
// which sizes the chunk, ST_SUM, which feeds the ten header words through the
// shared checksum adder, and ST_SEND, which presents the header; a response
// stall holds ST_SEND. Idle resumes once the last fragment is taken.
// Synchronous active-high reset clears the sequencer, the identification
// counter and local_ip. A stalled response holds its header until taken.
module ipv4_fragment_header_gen_top #(
   parameter int unsigned MTU = 1500
) (
   input  logic               clock,
   input  logic               reset,
   ipv4fhg_req_if.sink        req_if,
   ipv4fhg_rsp_if.source      rsp_if,
   ipv4fhg_csr_if.sink        csr_if
);

   localparam int unsigned CHUNK  = ((MTU - ipv4fhg_pkg::HDR_BYTES) / 8) * 8;
   localparam int unsigned PART_W = $clog2(CHUNK + 1);
   localparam int unsigned CW     = ipv4fhg_pkg::WORD_CNT_W;

   ipv4fhg_pkg::state_type    state_ff, state_in;
   ipv4fhg_pkg::csum_ctl_type csum_ctl;

   logic [CW-1:0]     word_cnt_ff, word_cnt_in;
   logic [15:0]       ident_ff, ident_in;
   logic [31:0]       local_ip_ff, local_ip_in;
   logic [15:0]       remaining_ff, remaining_in;
   logic [15:0]       offset_ff, offset_in;
   logic [PART_W-1:0] part_ff, part_in;
   logic              mf_ff, mf_in;
   logic [31:0]       dst_ff, dst_in;
   logic [7:0]        proto_ff, proto_in;

   logic              req_fire, rsp_fire, sum_done, needs_split;
   logic [15:0]       tlen;
   logic [15:0]       flag_off;
   logic [15:0]       hdr_words [ipv4fhg_pkg::NUM_WORDS];
   logic [15:0]       checksum;

   assign req_fire    = req_if.valid && req_if.ready;
   assign rsp_fire    = rsp_if.valid && rsp_if.ready;
   assign sum_done    = (word_cnt_ff == CW'(ipv4fhg_pkg::NUM_WORDS - 1));
   assign needs_split = (remaining_ff > 16'(CHUNK));

   assign tlen     = 16'(part_ff) + 16'(ipv4fhg_pkg::HDR_BYTES);
   assign flag_off = {2'b00, mf_ff, offset_ff[15:3]};

   assign hdr_words[0] = ipv4fhg_pkg::VER_IHL_TOS;
   assign hdr_words[1] = tlen;
   assign hdr_words[2] = ident_ff;
   assign hdr_words[3] = flag_off;
   assign hdr_words[4] = {ipv4fhg_pkg::TTL_VALUE, proto_ff};
   assign hdr_words[5] = 16'd0;
   assign hdr_words[6] = local_ip_ff[31:16];
   assign hdr_words[7] = local_ip_ff[15:0];
   assign hdr_words[8] = dst_ff[31:16];
   assign hdr_words[9] = dst_ff[15:0];

   ipv4fhg_csum u_csum (
      .clock    (clock),
      .ctl      (csum_ctl),
      .word     (hdr_words[word_cnt_ff]),
      .checksum (checksum)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ipv4fhg_pkg::ST_IDLE: begin
            if (req_fire) state_in = ipv4fhg_pkg::ST_FRAG;
         end
         ipv4fhg_pkg::ST_FRAG: state_in = ipv4fhg_pkg::ST_SUM;
         ipv4fhg_pkg::ST_SUM: begin
            if (sum_done) state_in = ipv4fhg_pkg::ST_SEND;
         end
         ipv4fhg_pkg::ST_SEND: begin
            if (rsp_fire) begin
               state_in = mf_ff ? ipv4fhg_pkg::ST_FRAG : ipv4fhg_pkg::ST_IDLE;
            end
         end
         default: state_in = ipv4fhg_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_if.ready   = 1'b0;
      rsp_if.valid   = 1'b0;
      csum_ctl.clear = 1'b0;
      csum_ctl.add   = 1'b0;
      case (state_ff)
         ipv4fhg_pkg::ST_IDLE: req_if.ready   = 1'b1;
         ipv4fhg_pkg::ST_FRAG: csum_ctl.clear = 1'b1;
         ipv4fhg_pkg::ST_SUM:  csum_ctl.add   = 1'b1;
         ipv4fhg_pkg::ST_SEND: rsp_if.valid   = 1'b1;
         default: ;
      endcase
   end

   assign csr_if.ready = 1'b1;

   // Datapath next values
   always_comb begin
      word_cnt_in  = word_cnt_ff;
      ident_in     = ident_ff;
      local_ip_in  = local_ip_ff;
      remaining_in = remaining_ff;
      offset_in    = offset_ff;
      part_in      = part_ff;
      mf_in        = mf_ff;
      dst_in       = dst_ff;
      proto_in     = proto_ff;

      if (csr_if.valid && csr_if.ready) local_ip_in = csr_if.local_ip;

      case (state_ff)
         ipv4fhg_pkg::ST_IDLE: begin
            if (req_fire) begin
               remaining_in = req_if.payload_len;
               offset_in    = '0;
               dst_in       = req_if.dst_ip;
               proto_in     = req_if.protocol;
            end
         end
         ipv4fhg_pkg::ST_FRAG: begin
            // size the chunk; the tail fits when no split is needed
            mf_in       = needs_split;
            part_in     = needs_split ? PART_W'(CHUNK) : remaining_ff[PART_W-1:0];
            word_cnt_in = '0;
         end
         ipv4fhg_pkg::ST_SUM: begin
            if (!sum_done) word_cnt_in = word_cnt_ff + CW'(1);
         end
         ipv4fhg_pkg::ST_SEND: begin
            if (rsp_fire) begin
               offset_in    = offset_ff + 16'(part_ff);
               remaining_in = remaining_ff - 16'(part_ff);
               if (!mf_ff) ident_in = ident_ff + 16'd1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ipv4fhg_pkg::ST_IDLE;
         word_cnt_ff <= '0;
         ident_ff    <= '0;
         local_ip_ff <= '0;
      end else begin
         state_ff    <= state_in;
         word_cnt_ff <= word_cnt_in;
         ident_ff    <= ident_in;
         local_ip_ff <= local_ip_in;
      end
   end

   always_ff @(posedge clock) begin
      remaining_ff <= remaining_in;
      offset_ff    <= offset_in;
      part_ff      <= part_in;
      mf_ff        <= mf_in;
      dst_ff       <= dst_in;
      proto_ff     <= proto_in;
   end

   assign rsp_if.total_len    = tlen[10:0];
   assign rsp_if.ident        = ident_ff;
   assign rsp_if.more_frags   = mf_ff;
   assign rsp_if.frag_offset  = offset_ff[15:3];
   assign rsp_if.proto_out    = proto_ff;
   assign rsp_if.dst_out      = dst_ff;
   assign rsp_if.hdr_checksum = checksum;
   assign rsp_if.last         = !mf_ff;

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> !req_if.ready && !rsp_if.valid)
      else $error("request accepted while a datagram is in progress");

   a_ident_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_if.last) |=> ident_ff == $past(ident_ff) + 16'd1)
      else $error("identification did not advance after the last fragment");

   a_ident_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_fire && rsp_if.more_frags) |=> ident_ff == $past(ident_ff)
                                          && state_ff == ipv4fhg_pkg::ST_FRAG)
      else $error("fragment sequence broken inside a datagram");

   a_sum_len: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ipv4fhg_pkg::ST_SUM && sum_done) |=> rsp_if.valid)
      else $error("checksum pass did not end in a response");

endmodule
